>>> design/ghash_pkg.sv
// shared types and constants for the ghash accumulator
package ghash_pkg;

	localparam int BLOCK_W     = 128;
	localparam int HALF_W      = 64;
	localparam int CNT_W       = 29;
	localparam int BYTES_W     = 5;
	localparam int BLOCK_BYTES = 16;

	typedef enum logic [1:0] {
		CMD_AAD    = 2'd0,
		CMD_DATA   = 2'd1,
		CMD_FINISH = 2'd2
	} cmd_t;

	typedef enum logic [0:0] {
		REG_HKEY_HIGH = 1'b0,
		REG_HKEY_LOW  = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		cmd_t               cmd;
		logic [HALF_W-1:0]  block_high;
		logic [HALF_W-1:0]  block_low;
		logic [BYTES_W-1:0] byte_count;
	} in_beat_t;

	typedef struct packed {
		logic [HALF_W-1:0] hash_high;
		logic [HALF_W-1:0] hash_low;
	} out_beat_t;

endpackage

>>> design/ghash_gfmul.sv
// combinational gf(2^128) multiplier in gcm bit order
module ghash_gfmul (
	input  logic [ghash_pkg::BLOCK_W-1:0] a,
	input  logic [ghash_pkg::BLOCK_W-1:0] h,
	output logic [ghash_pkg::BLOCK_W-1:0] p
);
	import ghash_pkg::*;

	logic [BLOCK_W-1:0]   a_rev;
	logic [BLOCK_W-1:0]   h_rev;
	logic [2*BLOCK_W-2:0] prod;
	logic [BLOCK_W-2:0]   prod_hi;
	logic [BLOCK_W+6:0]   fold;
	logic [6:0]           ovf;
	logic [BLOCK_W-1:0]   red;

	always_comb begin
		// gcm puts the x^0 coefficient in the top bit, so work on reversed words
		for (int i = 0; i < BLOCK_W; i++) begin
			a_rev[i] = a[BLOCK_W-1-i];
			h_rev[i] = h[BLOCK_W-1-i];
		end

		// carry-less product, one partial product per bit of h
		prod = '0;
		for (int i = 0; i < BLOCK_W; i++) begin
			if (h_rev[i]) begin
				prod = prod ^ ({{(BLOCK_W-1){1'b0}}, a_rev} << i);
			end
		end

		// x^128 = x^7 + x^2 + x + 1, folded twice
		prod_hi = prod[2*BLOCK_W-2:BLOCK_W];
		fold = {7'b0, prod[BLOCK_W-1:0]}
			^ {8'b0, prod_hi}
			^ {7'b0, prod_hi, 1'b0}
			^ {6'b0, prod_hi, 2'b0}
			^ {1'b0, prod_hi, 7'b0};
		ovf = fold[BLOCK_W+6:BLOCK_W];
		red = fold[BLOCK_W-1:0]
			^ {{(BLOCK_W-7){1'b0}}, ovf}
			^ {{(BLOCK_W-8){1'b0}}, ovf, 1'b0}
			^ {{(BLOCK_W-9){1'b0}}, ovf, 2'b0}
			^ {{(BLOCK_W-14){1'b0}}, ovf, 7'b0};

		for (int i = 0; i < BLOCK_W; i++) begin
			p[i] = red[BLOCK_W-1-i];
		end
	end

endmodule

>>> design/ghash_accumulator.sv
// ghash accumulator top level: input stage, y update with gf multiply, result register
// a finish beat is registered in the input stage; its hash is loaded into the result register when that stage advances
// throughput: one beat per cycle unless a finish beat waits on a full result register that is not being read;
//   the y feedback loop through the combinational gf(2^128) multiplier sets that figure
// reset: asynchronous, clears the running value, byte totals, hash subkey and all valid flags
module ghash_accumulator (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  ghash_pkg::in_beat_t   in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output ghash_pkg::out_beat_t  out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  ghash_pkg::cfg_reg_t   cfg_index,
	input  logic [ghash_pkg::HALF_W-1:0] cfg_data
);
	import ghash_pkg::*;

	logic [BLOCK_W-1:0] hkey_q;
	logic [BLOCK_W-1:0] acc_q;
	logic [CNT_W-1:0]   aad_q;
	logic [CNT_W-1:0]   data_q;

	logic               v_s1;
	cmd_t               cmd_s1;
	logic [BLOCK_W-1:0] blk_s1;
	logic [BYTES_W-1:0] n_s1;

	out_beat_t          out_q;
	logic               out_valid_q;

	logic               in_acc;
	logic               cmd_ok;
	logic [BYTES_W-1:0] n_in;
	logic [BLOCK_W-1:0] keep_mask;
	logic               adv;
	logic               is_fin;
	logic [BLOCK_W-1:0] x_blk;
	logic [BLOCK_W-1:0] mul_a;
	logic [BLOCK_W-1:0] mul_p;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hkey_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_HKEY_HIGH: hkey_q[BLOCK_W-1:HALF_W] <= cfg_data;
				REG_HKEY_LOW:  hkey_q[HALF_W-1:0]       <= cfg_data;
			endcase
		end
	end

	// input stage: saturate the byte count and zero the unused bytes
	always_comb begin
		cmd_ok = (in_data.cmd == CMD_AAD) || (in_data.cmd == CMD_DATA)
			|| (in_data.cmd == CMD_FINISH);
		n_in = (in_data.byte_count > BYTES_W'(BLOCK_BYTES)) ? BYTES_W'(BLOCK_BYTES)
			: in_data.byte_count;
		keep_mask = ~({BLOCK_W{1'b1}} >> {n_in, 3'b000});
	end

	assign is_fin   = (cmd_s1 == CMD_FINISH);
	assign adv      = v_s1 && (!is_fin || !out_valid_q || out_ready);
	assign in_ready = !v_s1 || adv;
	assign in_acc   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			// the unused command is taken and dropped here
			v_s1 <= in_valid && cmd_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_s1 <= in_data.cmd;
			blk_s1 <= {in_data.block_high, in_data.block_low} & keep_mask;
			n_s1   <= n_in;
		end
	end

	// finish folds in the lengths block, in bits
	assign x_blk = is_fin ? {32'b0, aad_q, 3'b000, 32'b0, data_q, 3'b000} : blk_s1;
	assign mul_a = acc_q ^ x_blk;

	ghash_gfmul u_gfmul (
		.a (mul_a),
		.h (hkey_q),
		.p (mul_p)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			aad_q  <= '0;
			data_q <= '0;
		end else if (adv) begin
			unique case (cmd_s1)
				CMD_AAD: begin
					acc_q <= mul_p;
					aad_q <= aad_q + CNT_W'(n_s1);
				end
				CMD_DATA: begin
					acc_q  <= mul_p;
					data_q <= data_q + CNT_W'(n_s1);
				end
				CMD_FINISH: begin
					acc_q  <= '0;
					aad_q  <= '0;
					data_q <= '0;
				end
				default: begin
					acc_q <= acc_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && is_fin) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && is_fin) begin
			out_q.hash_high <= mul_p[BLOCK_W-1:HALF_W];
			out_q.hash_low  <= mul_p[HALF_W-1:0];
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// finish leaves a clean running value and totals
	assert property (@(posedge clk) disable iff (!arst_n)
		adv && is_fin |=> (acc_q == '0) && (aad_q == '0) && (data_q == '0))
		else $error("state not cleared after finish");

	// a waiting result is never overwritten
	assert property (@(posedge clk) disable iff (!arst_n)
		adv && is_fin && out_valid_q |-> out_ready)
		else $error("result register overwritten");

	// a result appears only after a finish beat went through
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(adv && is_fin))
		else $error("result without finish");

	// the input stage holds only defined commands
	assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> (cmd_s1 == CMD_AAD) || (cmd_s1 == CMD_DATA) || (cmd_s1 == CMD_FINISH))
		else $error("unused command in input stage");

endmodule

>>> tb/tb_ghash_accumulator.sv
// testbench for the ghash accumulator: directed table, then random messages checked by a predictor
module tb_ghash_accumulator;
	import ghash_pkg::*;

	localparam logic [63:0]  ONES64      = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [127:0] GF_ONE      = {1'b1, 127'b0};
	localparam logic [7:0]   GF_POLY     = 8'hE1;
	localparam cmd_t         CMD_UNUSED  = cmd_t'(2'd3);
	localparam out_beat_t    NO_HASH     = '0;
	localparam int           SETTLE      = 4;
	localparam int           HOLD_CYCLES = 300;
	localparam int           N_PHASES    = 5;
	localparam int           PHASE_ITEMS = 250;
	localparam int           N_ROWS      = 22;

	typedef struct {
		logic         new_key;
		logic [127:0] key;
		in_beat_t     beat;
		logic         fixed;
		out_beat_t    hash;
	} dir_row_t;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      in_valid  = 1'b0;
	logic      in_ready;
	in_beat_t  in_data   = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_beat_t out_data;
	logic      cfg_valid = 1'b0;
	logic      cfg_ready;
	cfg_reg_t  cfg_index = REG_HKEY_HIGH;
	logic [63:0] cfg_data = '0;

	// predictor state
	logic [127:0] hkey       = '0;
	logic [127:0] y_acc      = '0;
	logic [28:0]  aad_total  = '0;
	logic [28:0]  data_total = '0;

	out_beat_t hash_q[$];
	out_beat_t want_hash;
	int        errors    = 0;
	bit        no_idle   = 1'b0;
	bit        hold_req  = 1'b0;
	bit        hold_done = 1'b0;

	// lengths checked at a glance use the gcm unit element or a zero subkey
	dir_row_t dir_rows [N_ROWS] = '{
		'{1'b0, 128'h0, '{CMD_FINISH, 64'h0, 64'h0, 5'd0}, 1'b1, '{64'h0, 64'h0}},
		'{1'b0, 128'h0, '{CMD_AAD, ONES64, ONES64, 5'd16}, 1'b0, '{64'h0, 64'h0}},
		'{1'b0, 128'h0, '{CMD_FINISH, ONES64, ONES64, 5'd31}, 1'b1, '{64'h0, 64'h0}},
		'{1'b1, GF_ONE, '{CMD_AAD, ONES64, ONES64, 5'd16}, 1'b0, '{64'h0, 64'h0}},
		'{1'b0, 128'h0, '{CMD_FINISH, 64'h0, 64'h0, 5'd0}, 1'b1,
			'{64'hFFFF_FFFF_FFFF_FF7F, ONES64}},
		'{1'b0, 128'h0, '{CMD_DATA, ONES64, ONES64, 5'd0}, 1'b0, '{64'h0, 64'h0}},
		'{1'b0, 128'h0, '{CMD_FINISH, 64'h0, 64'h0, 5'd0}, 1'b1, '{64'h0, 64'h0}},
		'{1'b0, 128'h0, '{CMD_DATA, ONES64, ONES64, 5'd31}, 1'b0, '{64'h0, 64'h0}},
		'{1'b0, 128'h0, '{CMD_FINISH, 64'h0, 64'h0, 5'd16}, 1'b1,
			'{ONES64, 64'hFFFF_FFFF_FFFF_FF7F}},
		'{1'b0, 128'h0, '{CMD_AAD, ONES64, ONES64, 5'd1}, 1'b0, '{64'h0, 64'h0}},
		'{1'b0, 128'h0, '{CMD_UNUSED, ONES64, ONES64, 5'd16}, 1'b0, '{64'h0, 64'h0}},
		'{1'b0, 128'h0, '{CMD_FINISH, 64'h0, 64'h0, 5'd0}, 1'b1,
			'{64'hFF00_0000_0000_0008, 64'h0}},
		'{1'b1, {ONES64, ONES64},
			'{CMD_AAD, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 5'd8},
			1'b0, '{64'h0, 64'h0}},
		'{1'b0, 128'h0, '{CMD_DATA, 64'hA5A5_A5A5_A5A5_A5A5, 64'h5A5A_5A5A_5A5A_5A5A, 5'd9},
			1'b0, '{64'h0, 64'h0}},
		'{1'b0, 128'h0, '{CMD_DATA, 64'h0F1E_2D3C_4B5A_6978, 64'h8796_A5B4_C3D2_E1F0, 5'd15},
			1'b0, '{64'h0, 64'h0}},
		'{1'b0, 128'h0, '{CMD_AAD, 64'hDEAD_BEEF_0BAD_F00D, 64'h1357_9BDF_2468_ACE0, 5'd7},
			1'b0, '{64'h0, 64'h0}},
		'{1'b0, 128'h0, '{CMD_UNUSED, 64'h0, 64'h0, 5'd0}, 1'b0, '{64'h0, 64'h0}},
		'{1'b0, 128'h0, '{CMD_FINISH, 64'h1234_5678_9ABC_DEF0, ONES64, 5'd19},
			1'b0, '{64'h0, 64'h0}},
		'{1'b0, 128'h0, '{CMD_DATA, 64'h0, 64'h0, 5'd16}, 1'b0, '{64'h0, 64'h0}},
		'{1'b0, 128'h0, '{CMD_FINISH, 64'h0, 64'h0, 5'd0}, 1'b0, '{64'h0, 64'h0}},
		'{1'b1, 128'h66E9_4BD4_EF8A_2C3B_884C_FA59_CA34_2B2E,
			'{CMD_DATA, 64'h0388_DACE_60B6_A392, 64'hF328_C2B9_71B2_FE78, 5'd16},
			1'b0, '{64'h0, 64'h0}},
		'{1'b0, 128'h0, '{CMD_FINISH, 64'h0, 64'h0, 5'd0}, 1'b0, '{64'h0, 64'h0}}
	};

	ghash_accumulator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// x * h in gf(2^128), bit 0 of an element is the top bit of byte 0
	function automatic logic [127:0] gf128_mul(input logic [127:0] x, input logic [127:0] hk);
		logic [127:0] z;
		logic [127:0] v;
		logic         carry;
		z = '0;
		v = x;
		for (int i = 0; i < 128; i++) begin
			if (hk[127-i]) begin
				z ^= v;
			end
			carry = v[0];
			v = v >> 1;
			if (carry) begin
				v[127:120] ^= GF_POLY;
			end
		end
		return z;
	endfunction

	// advances the running hash by one beat; returns 1 when a hash falls out
	function automatic bit ghash_step(input in_beat_t b, output out_beat_t h);
		logic [4:0]   n;
		logic [127:0] mask;
		h = NO_HASH;
		case (b.cmd)
			CMD_FINISH: begin
				y_acc ^= {32'd0, aad_total, 3'b000, 32'd0, data_total, 3'b000};
				y_acc = gf128_mul(y_acc, hkey);
				h = y_acc;
				y_acc = '0;
				aad_total = '0;
				data_total = '0;
				return 1'b1;
			end
			CMD_AAD, CMD_DATA: begin
				n = (b.byte_count > 5'd16) ? 5'd16 : b.byte_count;
				mask = (n == 5'd0) ? '0 : ~({128{1'b1}} >> {n, 3'b000});
				y_acc ^= {b.block_high, b.block_low} & mask;
				y_acc = gf128_mul(y_acc, hkey);
				if (b.cmd == CMD_AAD) begin
					aad_total = aad_total + 29'(n);
				end else begin
					data_total = data_total + 29'(n);
				end
				return 1'b0;
			end
			default: begin
				return 1'b0;
			end
		endcase
	endfunction

	function automatic in_beat_t rand_block(input cmd_t c, input bit last);
		in_beat_t b;
		b.cmd        = c;
		b.block_high = {$urandom, $urandom};
		b.block_low  = {$urandom, $urandom};
		b.byte_count = last ? 5'($urandom_range(1, 16)) : 5'd16;
		return b;
	endfunction

	task automatic send_beat(input in_beat_t b, input bit fixed, input out_beat_t fixed_hash);
		out_beat_t h;
		bit        emits;
		@(negedge clk);
		while (!no_idle && $urandom_range(0, 99) < 18) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= b;
		do @(posedge clk); while (!in_ready);
		emits = ghash_step(b, h);
		if (emits) begin
			hash_q.push_back(fixed ? fixed_hash : h);
		end
	endtask

	task automatic put_reg(input cfg_reg_t idx, input logic [63:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_HKEY_HIGH: hkey[127:64] = val;
			REG_HKEY_LOW:  hkey[63:0]   = val;
			default: ;
		endcase
	endtask

	// subkey only changes once the engine has drained
	task automatic load_hkey(input logic [127:0] key);
		@(negedge clk);
		in_valid <= 1'b0;
		while (hash_q.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
		put_reg(REG_HKEY_HIGH, key[127:64]);
		put_reg(REG_HKEY_LOW, key[63:0]);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// mostly whole messages, the rest stray beats with any command and length
	task automatic run_phase(input int n_items);
		int       sent;
		int       n_aad;
		int       n_dat;
		in_beat_t b;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 9) < 8) begin
				n_aad = $urandom_range(0, 3);
				n_dat = $urandom_range(0, 6);
				for (int k = 0; k < n_aad; k++) begin
					send_beat(rand_block(CMD_AAD, k == n_aad - 1), 1'b0, NO_HASH);
				end
				for (int k = 0; k < n_dat; k++) begin
					send_beat(rand_block(CMD_DATA, k == n_dat - 1), 1'b0, NO_HASH);
				end
				b = rand_block(CMD_FINISH, 1'b1);
				b.byte_count = 5'($urandom_range(0, 31));
				send_beat(b, 1'b0, NO_HASH);
				sent += n_aad + n_dat + 1;
			end else begin
				b = rand_block(cmd_t'($urandom_range(0, 3)), 1'b1);
				b.byte_count = 5'($urandom_range(0, 31));
				send_beat(b, 1'b0, NO_HASH);
				if (b.cmd != CMD_UNUSED) begin
					sent++;
				end
			end
		end
	endtask

	// receiver, with one long hold-off so the result register backs up
	initial begin
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_done = 1'b1;
			end
			out_ready <= no_idle || ($urandom_range(0, 99) >= 18);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (hash_q.size() == 0) begin
				$display("%0t unexpected hash beat: expected none, got %h", $time, out_data);
				errors++;
			end else begin
				want_hash = hash_q.pop_front();
				if (out_data.hash_high !== want_hash.hash_high) begin
					$display("%0t hash_high mismatch: expected %h, got %h", $time,
						want_hash.hash_high, out_data.hash_high);
					errors++;
				end
				if (out_data.hash_low !== want_hash.hash_low) begin
					$display("%0t hash_low mismatch: expected %h, got %h", $time,
						want_hash.hash_low, out_data.hash_low);
					errors++;
				end
			end
		end
	end

	initial begin
		#2000000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		logic [127:0] key;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		foreach (dir_rows[i]) begin
			if (dir_rows[i].new_key) begin
				load_hkey(dir_rows[i].key);
			end
			send_beat(dir_rows[i].beat, dir_rows[i].fixed, dir_rows[i].hash);
		end
		for (int p = 0; p < N_PHASES; p++) begin
			if (p == 1) begin
				key = GF_ONE >> $urandom_range(0, 127);
			end else begin
				key = {$urandom, $urandom, $urandom, $urandom};
			end
			load_hkey(key);
			hold_req = (p == 1);
			no_idle  = (p == 3);
			run_phase(PHASE_ITEMS);
		end
		@(negedge clk);
		in_valid <= 1'b0;
		while (hash_q.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

>>> sim.f
design/ghash_pkg.sv
design/ghash_gfmul.sv
design/ghash_accumulator.sv
tb/tb_ghash_accumulator.sv
